// ===== hw/rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg: shared types for the counting semaphore table
// Opcodes, status codes, controller states and the command/status words
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cst_pkg;

	localparam int unsigned FIFO_LIMIT = 8;

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_DELETE  = 3'd1,
		OP_IDENT   = 3'd2,
		OP_TAKE    = 3'd3,
		OP_GIVE    = 3'd4,
		OP_TIMEOUT = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_QUEUED    = 4'd1,
		ST_BAD_PARAM = 4'd2,
		ST_NO_SLOT   = 4'd3,
		ST_BAD_ID    = 4'd4,
		ST_UNAVAIL   = 4'd5,
		ST_FULL      = 4'd6,
		ST_NOT_FOUND = 4'd7,
		ST_Q_FULL    = 4'd8,
		ST_TIMED_OUT = 4'd9
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_INS_RD,
		S_INS_CMP,
		S_RM_RD,
		S_RM_CMP,
		S_RM_END,
		S_DEL_RD,
		S_DEL_EMIT,
		S_DEL_END
	} state_t;

	typedef enum logic [2:0] {QI_HOLD, QI_CLR, QI_LEN, QI_INC, QI_DEC} qi_op_t;
	typedef enum logic [1:0] {RD_NONE, RD_CUR, RD_PREV} rd_sel_t;
	typedef enum logic [1:0] {WR_NONE, WR_NEW, WR_UP, WR_DOWN} wr_sel_t;
	typedef enum logic [1:0] {ID_NONE, ID_NEW, ID_SLOT} id_sel_t;
	typedef enum logic [1:0] {WK_NONE, WK_CAP, WK_RD} wk_sel_t;

	// controller to datapath
	typedef struct packed {
		logic    ld_in;
		logic    scan_step;
		logic    do_create;
		logic    do_free;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    len_inc;
		logic    len_dec;
		logic    rm_step;
		qi_op_t  qi_op;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    emit;
		status_t st;
		id_sel_t id_sel;
		wk_sel_t wk_sel;
		logic    last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       scan_done;
		logic       found;
		logic       cnt_bad;
		logic       cnt_zero;
		logic       nowait;
		logic       len_zero;
		logic       len_full;
		logic       at_limit;
		logic       prio_mode;
		logic       qi_zero;
		logic       qi_at_len;
		logic       prio_le;
		logic       hit;
		logic       out_free;
	} sts_t;

endpackage

// ===== hw/rtl/cst_ctrl.sv =====
// ----------------------------------------------------------------------------
// cst_ctrl: operation sequencer
// Steps each operation through the slot scan, the queue walks and the
// result words.
// ----------------------------------------------------------------------------
module cst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cst_pkg::sts_t sts,
	output cst_pkg::cmd_t cmd
);

	cst_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == cst_pkg::S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cst_pkg::S_IDLE: begin
				if (in_valid) state_d = cst_pkg::S_SCAN;
			end
			cst_pkg::S_SCAN: begin
				if (sts.scan_done) state_d = cst_pkg::S_DECIDE;
			end
			cst_pkg::S_DECIDE: begin
				if (sts.out_free) begin
					state_d = cst_pkg::S_IDLE;
					if (sts.found) begin
						case (sts.op)
							cst_pkg::OP_DELETE: state_d = cst_pkg::S_DEL_RD;
							cst_pkg::OP_TAKE: begin
								if (sts.cnt_zero && !sts.nowait && !sts.len_full)
									state_d = cst_pkg::S_INS_RD;
							end
							cst_pkg::OP_GIVE: begin
								if (!sts.len_zero) state_d = cst_pkg::S_RM_RD;
							end
							cst_pkg::OP_TIMEOUT: state_d = cst_pkg::S_RM_RD;
							default: state_d = cst_pkg::S_IDLE;
						endcase
					end
				end
			end
			cst_pkg::S_INS_RD: begin
				if (sts.qi_zero || !sts.prio_mode) begin
					if (sts.out_free) state_d = cst_pkg::S_IDLE;
				end else begin
					state_d = cst_pkg::S_INS_CMP;
				end
			end
			cst_pkg::S_INS_CMP: begin
				if (!sts.prio_le) state_d = cst_pkg::S_INS_RD;
				else if (sts.out_free) state_d = cst_pkg::S_IDLE;
			end
			cst_pkg::S_RM_RD: begin
				state_d = sts.qi_at_len ? cst_pkg::S_RM_END : cst_pkg::S_RM_CMP;
			end
			cst_pkg::S_RM_CMP: state_d = cst_pkg::S_RM_RD;
			cst_pkg::S_RM_END: begin
				if (sts.out_free) state_d = cst_pkg::S_IDLE;
			end
			cst_pkg::S_DEL_RD: begin
				state_d = sts.qi_at_len ? cst_pkg::S_DEL_END : cst_pkg::S_DEL_EMIT;
			end
			cst_pkg::S_DEL_EMIT: begin
				if (sts.out_free) state_d = cst_pkg::S_DEL_RD;
			end
			cst_pkg::S_DEL_END: begin
				if (sts.out_free) state_d = cst_pkg::S_IDLE;
			end
			default: state_d = cst_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd        = '0;
		cmd.qi_op  = cst_pkg::QI_HOLD;
		cmd.rd_sel = cst_pkg::RD_NONE;
		cmd.wr_sel = cst_pkg::WR_NONE;
		cmd.st     = cst_pkg::ST_OK;
		cmd.id_sel = cst_pkg::ID_NONE;
		cmd.wk_sel = cst_pkg::WK_NONE;
		case (state_q)
			cst_pkg::S_IDLE: begin
				cmd.ld_in = in_valid;
			end
			cst_pkg::S_SCAN: begin
				cmd.scan_step = !sts.scan_done;
			end
			cst_pkg::S_DECIDE: begin
				if (sts.out_free) begin
					cmd.last = 1'b1;
					case (sts.op)
						cst_pkg::OP_CREATE: begin
							cmd.emit = 1'b1;
							if (sts.cnt_bad) begin
								cmd.st = cst_pkg::ST_BAD_PARAM;
							end else if (!sts.found) begin
								cmd.st = cst_pkg::ST_NO_SLOT;
							end else begin
								cmd.do_create = 1'b1;
								cmd.id_sel    = cst_pkg::ID_NEW;
							end
						end
						cst_pkg::OP_IDENT: begin
							cmd.emit = 1'b1;
							if (sts.found) cmd.id_sel = cst_pkg::ID_SLOT;
							else cmd.st = cst_pkg::ST_NOT_FOUND;
						end
						cst_pkg::OP_DELETE, cst_pkg::OP_TAKE,
						cst_pkg::OP_GIVE, cst_pkg::OP_TIMEOUT: begin
							if (!sts.found) begin
								cmd.emit = 1'b1;
								cmd.st   = cst_pkg::ST_BAD_ID;
							end else begin
								case (sts.op)
									cst_pkg::OP_DELETE: cmd.qi_op = cst_pkg::QI_CLR;
									cst_pkg::OP_TAKE: begin
										if (!sts.cnt_zero) begin
											cmd.cnt_dec = 1'b1;
											cmd.emit    = 1'b1;
										end else if (sts.nowait) begin
											cmd.emit = 1'b1;
											cmd.st   = cst_pkg::ST_UNAVAIL;
										end else if (sts.len_full) begin
											cmd.emit = 1'b1;
											cmd.st   = cst_pkg::ST_Q_FULL;
										end else begin
											cmd.qi_op = cst_pkg::QI_LEN;
										end
									end
									cst_pkg::OP_GIVE: begin
										if (!sts.len_zero) begin
											cmd.qi_op = cst_pkg::QI_CLR;
										end else if (sts.at_limit) begin
											cmd.emit = 1'b1;
											cmd.st   = cst_pkg::ST_FULL;
										end else begin
											cmd.cnt_inc = 1'b1;
											cmd.emit    = 1'b1;
										end
									end
									default: cmd.qi_op = cst_pkg::QI_CLR;
								endcase
							end
						end
						default: begin
							cmd.emit = 1'b1;
							cmd.st   = cst_pkg::ST_BAD_PARAM;
						end
					endcase
				end
			end
			cst_pkg::S_INS_RD: begin
				if (sts.qi_zero || !sts.prio_mode) begin
					if (sts.out_free) begin
						cmd.wr_sel  = cst_pkg::WR_NEW;
						cmd.len_inc = 1'b1;
						cmd.emit    = 1'b1;
						cmd.st      = cst_pkg::ST_QUEUED;
						cmd.last    = 1'b1;
					end
				end else begin
					cmd.rd_sel = cst_pkg::RD_PREV;
				end
			end
			cst_pkg::S_INS_CMP: begin
				if (!sts.prio_le) begin
					cmd.wr_sel = cst_pkg::WR_UP;
					cmd.qi_op  = cst_pkg::QI_DEC;
				end else if (sts.out_free) begin
					cmd.wr_sel  = cst_pkg::WR_NEW;
					cmd.len_inc = 1'b1;
					cmd.emit    = 1'b1;
					cmd.st      = cst_pkg::ST_QUEUED;
					cmd.last    = 1'b1;
				end
			end
			cst_pkg::S_RM_RD: begin
				if (!sts.qi_at_len) cmd.rd_sel = cst_pkg::RD_CUR;
			end
			cst_pkg::S_RM_CMP: begin
				cmd.rm_step = 1'b1;
				cmd.wr_sel  = cst_pkg::WR_DOWN;
				cmd.qi_op   = cst_pkg::QI_INC;
			end
			cst_pkg::S_RM_END: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.last    = 1'b1;
					cmd.len_dec = sts.hit;
					if (!sts.hit) begin
						cmd.st = cst_pkg::ST_NOT_FOUND;
					end else if (sts.op == cst_pkg::OP_GIVE) begin
						cmd.wk_sel = cst_pkg::WK_CAP;
					end else begin
						cmd.st = cst_pkg::ST_TIMED_OUT;
					end
				end
			end
			cst_pkg::S_DEL_RD: begin
				if (!sts.qi_at_len) cmd.rd_sel = cst_pkg::RD_CUR;
			end
			cst_pkg::S_DEL_EMIT: begin
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.wk_sel = cst_pkg::WK_RD;
					cmd.qi_op  = cst_pkg::QI_INC;
				end
			end
			cst_pkg::S_DEL_END: begin
				if (sts.out_free) begin
					cmd.do_free = 1'b1;
					cmd.emit    = 1'b1;
					cmd.last    = 1'b1;
				end
			end
			default: cmd.emit = 1'b0;
		endcase
	end

	// an accepted word always starts the slot scan
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == cst_pkg::S_SCAN))
		else $error("accepted word did not start the scan");

	// no result word is produced while waiting for input
	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cst_pkg::S_IDLE) |-> !cmd.emit)
		else $error("result word emitted while idle");

	// the decide step never repeats once the output is free
	a_decide_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cst_pkg::S_DECIDE && sts.out_free) |=> (state_q != cst_pkg::S_DECIDE))
		else $error("decide step repeated");

endmodule

// ===== hw/rtl/cst_dp.sv =====
// ----------------------------------------------------------------------------
// cst_dp: semaphore table datapath
// Slot registers, wait-queue memory, slot scan, queue walk index and the
// result register.
// ----------------------------------------------------------------------------
module cst_dp #(
	parameter int unsigned NUM_SLOTS   = 8,
	parameter int unsigned QUEUE_DEPTH = 8,
	parameter int unsigned MAX_COUNT   = 255
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [2:0]    opcode,
	input  logic [31:0]   sem_id,
	input  logic [31:0]   sem_name,
	input  logic [7:0]    start_count,
	input  logic          priority_mode,
	input  logic          no_wait,
	input  logic [7:0]    task_id,
	input  logic [7:0]    task_priority,
	input  cst_pkg::cmd_t cmd,
	output cst_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [3:0]    status,
	output logic [31:0]   sem_id_out,
	output logic [7:0]    woken_task,
	output logic          woken_valid,
	output logic          last
);

	localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SKW = $clog2(NUM_SLOTS + 1);
	localparam int QLW = $clog2(QUEUE_DEPTH + 1);
	localparam int QN  = NUM_SLOTS * QUEUE_DEPTH;
	localparam int AW  = (QN > 1) ? $clog2(QN) : 1;
	localparam int CW  = $clog2(MAX_COUNT + 1);

	// latched operation
	logic [2:0]  op_q;
	logic [31:0] id_q, name_q;
	logic [7:0]  icnt_q, task_q, prio_q;
	logic        pmode_q, nowait_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			op_q     <= opcode;
			id_q     <= sem_id;
			name_q   <= sem_name;
			icnt_q   <= start_count;
			pmode_q  <= priority_mode;
			nowait_q <= no_wait;
			task_q   <= task_id;
			prio_q   <= task_priority;
		end
	end

	// slot registers
	logic          used_q  [NUM_SLOTS];
	logic [31:0]   ident_q [NUM_SLOTS];
	logic [31:0]   label_q [NUM_SLOTS];
	logic [CW-1:0] count_q [NUM_SLOTS];
	logic [CW-1:0] limit_q [NUM_SLOTS];
	logic          mode_q  [NUM_SLOTS];
	logic [SW-1:0] age_q   [NUM_SLOTS];
	logic [QLW-1:0] qlen_q [NUM_SLOTS];
	logic [31:0]   next_ident_q;

	// scan state
	logic [SKW-1:0] k_q;
	logic           found_q;
	logic [SW-1:0]  fidx_q, best_age_q;
	logic [SW-1:0]  ksel;
	logic           cand;

	assign ksel = k_q[SW-1:0];

	// candidate test for the slot under the scan
	always_comb begin
		case (op_q)
			cst_pkg::OP_CREATE: cand = !used_q[ksel] && !found_q;
			cst_pkg::OP_IDENT: cand = used_q[ksel] && (label_q[ksel] == name_q) &&
				(!found_q || (age_q[ksel] < best_age_q));
			default: cand = (id_q != 32'd0) && used_q[ksel] && (ident_q[ksel] == id_q) &&
				(!found_q || (age_q[ksel] < best_age_q));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			found_q    <= 1'b0;
			fidx_q     <= '0;
			best_age_q <= '0;
		end else if (cmd.ld_in) begin
			k_q     <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			k_q <= k_q + 1'b1;
			if (cand) begin
				found_q    <= 1'b1;
				fidx_q     <= ksel;
				best_age_q <= age_q[ksel];
			end
		end
	end

	// slot updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_SLOTS; j++) begin
				used_q[j]  <= 1'b0;
				ident_q[j] <= '0;
				label_q[j] <= '0;
				count_q[j] <= '0;
				limit_q[j] <= '0;
				mode_q[j]  <= 1'b0;
				age_q[j]   <= '0;
				qlen_q[j]  <= '0;
			end
			next_ident_q <= 32'd1;
		end else begin
			if (cmd.do_create) begin
				for (int j = 0; j < NUM_SLOTS; j++) begin
					if (used_q[j]) age_q[j] <= age_q[j] + 1'b1;
				end
				used_q[fidx_q]  <= 1'b1;
				age_q[fidx_q]   <= '0;
				ident_q[fidx_q] <= next_ident_q;
				label_q[fidx_q] <= name_q;
				count_q[fidx_q] <= CW'(icnt_q);
				mode_q[fidx_q]  <= pmode_q;
				limit_q[fidx_q] <= pmode_q ? CW'(MAX_COUNT) : CW'(cst_pkg::FIFO_LIMIT);
				qlen_q[fidx_q]  <= '0;
				next_ident_q    <= (next_ident_q == 32'hFFFF_FFFF) ? 32'd1
					: next_ident_q + 32'd1;
			end
			if (cmd.do_free) begin
				for (int j = 0; j < NUM_SLOTS; j++) begin
					if (used_q[j] && (age_q[j] > age_q[fidx_q])) age_q[j] <= age_q[j] - 1'b1;
				end
				used_q[fidx_q]  <= 1'b0;
				ident_q[fidx_q] <= '0;
				label_q[fidx_q] <= '0;
				count_q[fidx_q] <= '0;
				limit_q[fidx_q] <= '0;
				mode_q[fidx_q]  <= 1'b0;
				age_q[fidx_q]   <= '0;
				qlen_q[fidx_q]  <= '0;
			end
			if (cmd.cnt_inc) count_q[fidx_q] <= count_q[fidx_q] + 1'b1;
			if (cmd.cnt_dec) count_q[fidx_q] <= count_q[fidx_q] - 1'b1;
			if (cmd.len_inc) qlen_q[fidx_q] <= qlen_q[fidx_q] + 1'b1;
			if (cmd.len_dec) qlen_q[fidx_q] <= qlen_q[fidx_q] - 1'b1;
		end
	end

	// queue walk index and removal hit
	logic [QLW-1:0] qi_q;
	logic           hit_q;
	logic [7:0]     cap_q;
	logic [7:0]     rd_task_q, rd_prio_q;
	logic           match;

	assign match = (op_q == cst_pkg::OP_GIVE) ? (qi_q == '0) : (rd_task_q == task_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qi_q  <= '0;
			hit_q <= 1'b0;
		end else begin
			case (cmd.qi_op)
				cst_pkg::QI_CLR: begin
					qi_q  <= '0;
					hit_q <= 1'b0;
				end
				cst_pkg::QI_LEN: qi_q <= qlen_q[fidx_q];
				cst_pkg::QI_INC: qi_q <= qi_q + 1'b1;
				cst_pkg::QI_DEC: qi_q <= qi_q - 1'b1;
				default: qi_q <= qi_q;
			endcase
			if (cmd.rm_step && !hit_q && match) hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rm_step && !hit_q && match) cap_q <= rd_task_q;
	end

	// wait-queue memory
	logic [7:0]    mem_task [QN];
	logic [7:0]    mem_prio [QN];
	logic [AW-1:0] base, ra, wa;
	logic          we;
	logic [7:0]    wd_task, wd_prio;

	assign base = AW'(32'(fidx_q) * QUEUE_DEPTH);

	always_comb begin
		ra = base + AW'(qi_q);
		if (cmd.rd_sel == cst_pkg::RD_PREV) ra = base + AW'(qi_q) - 1'b1;
	end

	always_comb begin
		we      = 1'b0;
		wa      = base + AW'(qi_q);
		wd_task = rd_task_q;
		wd_prio = rd_prio_q;
		case (cmd.wr_sel)
			cst_pkg::WR_NEW: begin
				we      = 1'b1;
				wd_task = task_q;
				wd_prio = prio_q;
			end
			cst_pkg::WR_UP: we = 1'b1;
			cst_pkg::WR_DOWN: begin
				we = hit_q;
				wa = base + AW'(qi_q) - 1'b1;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_task[wa] <= wd_task;
			mem_prio[wa] <= wd_prio;
		end
		if (cmd.rd_sel != cst_pkg::RD_NONE) begin
			rd_task_q <= mem_task[ra];
			rd_prio_q <= mem_prio[ra];
		end
	end

	// result register
	logic        out_valid_q;
	logic [3:0]  status_q;
	logic [31:0] id_out_q;
	logic [7:0]  woken_q;
	logic        wvalid_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.st;
			last_q   <= cmd.last;
			case (cmd.id_sel)
				cst_pkg::ID_NEW: id_out_q <= next_ident_q;
				cst_pkg::ID_SLOT: id_out_q <= ident_q[fidx_q];
				default: id_out_q <= 32'd0;
			endcase
			case (cmd.wk_sel)
				cst_pkg::WK_CAP: begin
					woken_q  <= cap_q;
					wvalid_q <= 1'b1;
				end
				cst_pkg::WK_RD: begin
					woken_q  <= rd_task_q;
					wvalid_q <= 1'b1;
				end
				default: begin
					woken_q  <= 8'd0;
					wvalid_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign sem_id_out  = id_out_q;
	assign woken_task  = woken_q;
	assign woken_valid = wvalid_q;
	assign last        = last_q;

	// status to the controller
	always_comb begin
		sts           = '0;
		sts.op        = op_q;
		sts.scan_done = (k_q == SKW'(NUM_SLOTS));
		sts.found     = found_q;
		sts.cnt_bad   = (32'(icnt_q) > 32'(MAX_COUNT));
		sts.cnt_zero  = (count_q[fidx_q] == '0);
		sts.nowait    = nowait_q;
		sts.len_zero  = (qlen_q[fidx_q] == '0);
		sts.len_full  = (qlen_q[fidx_q] == QLW'(QUEUE_DEPTH));
		sts.at_limit  = (count_q[fidx_q] >= limit_q[fidx_q]);
		sts.prio_mode = mode_q[fidx_q];
		sts.qi_zero   = (qi_q == '0);
		sts.qi_at_len = (qi_q == qlen_q[fidx_q]);
		sts.prio_le   = (rd_prio_q <= prio_q);
		sts.hit       = hit_q;
		sts.out_free  = !out_valid_q || out_ready;
	end

	a_qi_range: assert property (@(posedge clk) disable iff (!arst_n)
		qi_q <= QLW'(QUEUE_DEPTH))
		else $error("queue walk index out of range");

	a_ident_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_ident_q != 32'd0)
		else $error("next identifier is zero");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result word overwritten");

endmodule

// ===== hw/rtl/counting_semaphore_table.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_table: hardware semaphore table
// Create, delete, ident, take, give and waiter timeout on a table of slots,
// each with a count, a limit and a FIFO or priority wait queue.
//
//  channel  | dir | tdata                                   | tuser       | tlast
//  s_axis   | in  | sem_id,sem_name,start_count,priority_   | opcode      | -
//           |     | mode,no_wait,task_id,task_priority      |             |
//  m_axis   | out | status,sem_id_out,woken_task            | woken_valid | last
//
// A word passes the accept state, the slot scan over every slot and the decide
// state; queue work adds, for each queue entry walked, a memory read and then
// a compare and write (for delete, an emit) before the closing result word.
// Delete gives one result word per waiter plus a final word.
// No clearing pass: the queue memory is only read below the queue length.
// A stalled m_axis holds the engine at its next result word; a finished
// result may wait in the output register while a new word is accepted.
// ----------------------------------------------------------------------------
module counting_semaphore_table #(
	parameter int unsigned NUM_SLOTS   = 8,
	parameter int unsigned QUEUE_DEPTH = 8,
	parameter int unsigned MAX_COUNT   = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// sem_id[31:0], sem_name[63:32], start_count[71:64], priority_mode[72],
	// no_wait[73], task_id[81:74], task_priority[89:82]
	input  logic [95:0] s_axis_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[3:0], sem_id_out[35:4], woken_task[43:36]
	output logic [47:0] m_axis_tdata,
	// woken_valid[0]
	output logic        m_axis_tuser,
	output logic        m_axis_tlast
);

	cst_pkg::cmd_t cmd;
	cst_pkg::sts_t sts;
	logic [3:0]    status;
	logic [31:0]   sem_id_out;
	logic [7:0]    woken_task;

	cst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cst_dp #(
		.NUM_SLOTS   (NUM_SLOTS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_COUNT   (MAX_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.opcode        (s_axis_tuser),
		.sem_id        (s_axis_tdata[31:0]),
		.sem_name      (s_axis_tdata[63:32]),
		.start_count   (s_axis_tdata[71:64]),
		.priority_mode (s_axis_tdata[72]),
		.no_wait       (s_axis_tdata[73]),
		.task_id       (s_axis_tdata[81:74]),
		.task_priority (s_axis_tdata[89:82]),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.status        (status),
		.sem_id_out    (sem_id_out),
		.woken_task    (woken_task),
		.woken_valid   (m_axis_tuser),
		.last          (m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, woken_task, sem_id_out, status};

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: counting semaphore table
// Drives create/delete/ident/take/give/timeout words into the table, keeps
// its own model of slots and wait queues, and checks every result word in
// order against the predicted ones. Both sides idle at random; one long
// receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 8;
	localparam int QDEPTH = 8;
	localparam int MAXCNT = 255;

	typedef struct {
		logic [2:0]  opcode;
		logic [31:0] sem_id;
		logic [31:0] sem_name;
		logic [7:0]  start_count;
		logic        priority_mode;
		logic        no_wait;
		logic [7:0]  task_id;
		logic [7:0]  task_priority;
	} sem_req_t;

	typedef struct {
		logic [3:0]  status;
		logic [31:0] sem_id_out;
		logic [7:0]  woken_task;
		logic        woken_valid;
		logic        last;
	} sem_resp_t;

	// semaphore table model and queue of expected result words
	class sem_scoreboard;
		bit          used[NSLOT];
		logic [31:0] ident[NSLOT];
		logic [31:0] label[NSLOT];
		int          count[NSLOT];
		int          limit[NSLOT];
		bit          pmode[NSLOT];
		int          age[NSLOT];
		logic [7:0]  wtask[NSLOT][$];
		logic [7:0]  wprio[NSLOT][$];
		logic [31:0] next_ident = 1;
		sem_resp_t   pending[$];
		int          errors;

		function void push(logic [3:0] st, logic [31:0] id = 0, logic [7:0] tk = 0,
				logic v = 0, logic l = 1);
			sem_resp_t r;
			r.status = st; r.sem_id_out = id; r.woken_task = tk;
			r.woken_valid = v; r.last = l;
			pending.push_back(r);
		endfunction

		function int find_id(logic [31:0] id);
			int best;
			best = -1;
			if (id == 0) return -1;
			for (int s = 0; s < NSLOT; s++)
				if (used[s] && ident[s] == id && (best < 0 || age[s] < age[best]))
					best = s;
			return best;
		endfunction

		function int find_name(logic [31:0] nm);
			int best;
			best = -1;
			for (int s = 0; s < NSLOT; s++)
				if (used[s] && label[s] == nm && (best < 0 || age[s] < age[best]))
					best = s;
			return best;
		endfunction

		// note an accepted input word
		function void accept(sem_req_t q);
			int s, pos;
			if (q.opcode == cst_pkg::OP_CREATE) begin
				s = -1;
				for (int k = NSLOT - 1; k >= 0; k--)
					if (!used[k]) s = k;
				if (s < 0) begin
					push(cst_pkg::ST_NO_SLOT);
					return;
				end
				for (int k = 0; k < NSLOT; k++)
					if (used[k]) age[k]++;
				used[s] = 1; age[s] = 0; ident[s] = next_ident;
				next_ident++;
				if (next_ident == 0) next_ident = 1;
				label[s] = q.sem_name; count[s] = int'(q.start_count);
				pmode[s] = q.priority_mode;
				limit[s] = q.priority_mode ? MAXCNT : int'(cst_pkg::FIFO_LIMIT);
				wtask[s].delete(); wprio[s].delete();
				push(cst_pkg::ST_OK, ident[s]);
				return;
			end
			if (q.opcode == cst_pkg::OP_IDENT) begin
				s = find_name(q.sem_name);
				if (s < 0) push(cst_pkg::ST_NOT_FOUND);
				else push(cst_pkg::ST_OK, ident[s]);
				return;
			end
			if (q.opcode > cst_pkg::OP_TIMEOUT) begin
				push(cst_pkg::ST_BAD_PARAM);
				return;
			end
			s = find_id(q.sem_id);
			if (s < 0) begin
				push(cst_pkg::ST_BAD_ID);
				return;
			end
			case (q.opcode)
				cst_pkg::OP_DELETE: begin
					while (wtask[s].size() > 0) begin
						push(cst_pkg::ST_OK, 0, wtask[s].pop_front(), 1, 0);
						void'(wprio[s].pop_front());
					end
					for (int j = 0; j < NSLOT; j++)
						if (used[j] && age[j] > age[s]) age[j]--;
					used[s] = 0; ident[s] = 0; label[s] = 0; count[s] = 0;
					limit[s] = 0; pmode[s] = 0; age[s] = 0;
					push(cst_pkg::ST_OK);
				end
				cst_pkg::OP_TAKE: begin
					if (count[s] > 0) begin
						count[s]--;
						push(cst_pkg::ST_OK);
					end else if (q.no_wait) begin
						push(cst_pkg::ST_UNAVAIL);
					end else if (wtask[s].size() >= QDEPTH) begin
						push(cst_pkg::ST_Q_FULL);
					end else begin
						pos = wtask[s].size();
						if (pmode[s]) begin
							pos = 0;
							while (pos < wtask[s].size() && wprio[s][pos] <= q.task_priority)
								pos++;
						end
						wtask[s].insert(pos, q.task_id);
						wprio[s].insert(pos, q.task_priority);
						push(cst_pkg::ST_QUEUED);
					end
				end
				cst_pkg::OP_GIVE: begin
					if (wtask[s].size() > 0) begin
						push(cst_pkg::ST_OK, 0, wtask[s].pop_front(), 1);
						void'(wprio[s].pop_front());
					end else if (count[s] >= limit[s]) begin
						push(cst_pkg::ST_FULL);
					end else begin
						count[s]++;
						push(cst_pkg::ST_OK);
					end
				end
				default: begin
					for (int i = 0; i < wtask[s].size(); i++)
						if (wtask[s][i] == q.task_id) begin
							wtask[s].delete(i); wprio[s].delete(i);
							push(cst_pkg::ST_TIMED_OUT);
							return;
						end
					push(cst_pkg::ST_NOT_FOUND);
				end
			endcase
		endfunction

		// compare one result word against the oldest expectation
		function void check(sem_resp_t a);
			sem_resp_t e;
			if (pending.size() == 0) begin
				$error("unexpected result word status=%0d", a.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, a.status); errors++;
			end
			if (a.sem_id_out !== e.sem_id_out) begin
				$error("sem_id_out: expected %0h, got %0h", e.sem_id_out, a.sem_id_out);
				errors++;
			end
			if (a.woken_task !== e.woken_task) begin
				$error("woken_task: expected %0d, got %0d", e.woken_task, a.woken_task);
				errors++;
			end
			if (a.woken_valid !== e.woken_valid) begin
				$error("woken_valid: expected %0d, got %0d", e.woken_valid, a.woken_valid);
				errors++;
			end
			if (a.last !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, a.last); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	sem_scoreboard sb = new();
	bit            quiet;
	bit            hold_off;
	bit            stim_done;
	longint        cycles;

	counting_semaphore_table DUT (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	// result side: sample accepted words, random stall bursts
	always @(posedge clk) begin
		sem_resp_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			r.status = m_axis_tdata[3:0];
			r.sem_id_out = m_axis_tdata[35:4];
			r.woken_task = m_axis_tdata[43:36];
			r.woken_valid = m_axis_tuser;
			r.last = m_axis_tlast;
			sb.check(r);
		end
	end

	initial begin
		int n;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end else if (!quiet && $urandom_range(3) == 0) begin
				m_axis_tready <= 0;
				n = $urandom_range(13, 1);
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				@(posedge clk);
			end
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	task automatic send(sem_req_t q);
		int n;
		if (!quiet && $urandom_range(3) == 0) begin
			s_axis_tvalid <= 0;
			n = $urandom_range(13, 1);
			repeat (n) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= q.opcode;
		s_axis_tdata <= {6'b0, q.task_priority, q.task_id, q.no_wait, q.priority_mode,
			q.start_count, q.sem_name, q.sem_id};
		do @(posedge clk); while (!s_axis_tready);
		sb.accept(q);
	endtask

	function automatic sem_req_t mk(logic [2:0] op, logic [31:0] id = 0,
			logic [31:0] nm = 0, logic [7:0] cnt = 0, logic pm = 0, logic nw = 0,
			logic [7:0] tk = 0, logic [7:0] pr = 0);
		sem_req_t q;
		q.opcode = op; q.sem_id = id; q.sem_name = nm; q.start_count = cnt;
		q.priority_mode = pm; q.no_wait = nw; q.task_id = tk; q.task_priority = pr;
		return q;
	endfunction

	// random word biased toward live identifiers and names
	function automatic sem_req_t rand_req();
		sem_req_t q;
		int s;
		q = mk(3'($urandom_range(5)), 0, 32'h5345_4d00 | $urandom_range(3),
			8'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)),
			1'($urandom_range(1)), $urandom_range(3) == 0, 8'($urandom_range(7)),
			8'($urandom_range(3)));
		if ($urandom_range(31) == 0) q.opcode = 3'($urandom_range(7, 6));
		if ($urandom_range(15) == 0) q.sem_name = $urandom;
		if ($urandom_range(3) == 0) q.task_id = 8'($urandom);
		if ($urandom_range(3) == 0) q.task_priority = 8'($urandom);
		s = $urandom_range(NSLOT - 1);
		if (sb.used[s] && $urandom_range(7) != 0) q.sem_id = sb.ident[s];
		else q.sem_id = $urandom_range(1) ? $urandom : $urandom_range(12);
		if (q.opcode == cst_pkg::OP_DELETE && $urandom_range(2) != 0)
			q.opcode = cst_pkg::OP_TAKE;
		return q;
	endfunction

	initial begin
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		quiet = 0;
		hold_off = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: create, queue in priority order, give, timeout, delete
		send(mk(cst_pkg::OP_IDENT, 0, 32'hFFFF_FFFF));
		send(mk(cst_pkg::OP_CREATE, 0, 32'hFFFF_FFFF, 8'hFF, 0));
		send(mk(cst_pkg::OP_GIVE, 1));
		send(mk(cst_pkg::OP_CREATE, 0, 32'h0, 8'h0, 1));
		send(mk(cst_pkg::OP_TAKE, 2, 0, 0, 0, 1, 8'h01, 8'h00));
		send(mk(cst_pkg::OP_TAKE, 2, 0, 0, 0, 0, 8'hFF, 8'hFF));
		send(mk(cst_pkg::OP_TAKE, 2, 0, 0, 0, 0, 8'h10, 8'h05));
		send(mk(cst_pkg::OP_TAKE, 2, 0, 0, 0, 0, 8'h11, 8'h05));
		send(mk(cst_pkg::OP_TAKE, 2, 0, 0, 0, 0, 8'h00, 8'h00));
		send(mk(cst_pkg::OP_TIMEOUT, 2, 0, 0, 0, 0, 8'h10));
		send(mk(cst_pkg::OP_TIMEOUT, 2, 0, 0, 0, 0, 8'h77));
		send(mk(cst_pkg::OP_GIVE, 2));
		send(mk(cst_pkg::OP_IDENT, 0, 32'h0));
		send(mk(cst_pkg::OP_DELETE, 2));
		send(mk(cst_pkg::OP_DELETE, 2));
		send(mk(cst_pkg::OP_DELETE, 0));
		send(mk(3'd6));
		send(mk(3'd7, 32'hFFFF_FFFF));
		// fill the table under one name, look that name up, then a full-queue FIFO slot
		for (int i = 0; i < NSLOT; i++)
			send(mk(cst_pkg::OP_CREATE, 0, 32'hABCD_0000, 8'd0, i[0]));
		send(mk(cst_pkg::OP_CREATE));
		send(mk(cst_pkg::OP_IDENT, 0, 32'hABCD_0000));
		for (int i = 0; i <= QDEPTH; i++)
			send(mk(cst_pkg::OP_TAKE, 3, 0, 0, 0, 0, i[7:0], 8'd1));
		send(mk(cst_pkg::OP_DELETE, 3));
		// long receiver hold-off while sender keeps offering
		hold_off = 1;
		for (int i = 0; i < 190; i++) begin
			if (i == 160) quiet = 1;
			send(rand_req());
		end
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
